// ----- src/lbfs_pkg.sv -----
package lbfs_pkg;

  // default sizes of the store
  localparam int FileSlotsDef  = 64;
  localparam int BlockCountDef = 256;
  localparam int BlockBytesDef = 64;

  typedef enum logic [2:0] {
    REQ_CREATE = 3'd0,
    REQ_OPEN   = 3'd1,
    REQ_READ   = 3'd2,
    REQ_WRITE  = 3'd3,
    REQ_APPEND = 3'd4,
    REQ_CLOSE  = 3'd5,
    REQ_DELETE = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SLOT    = 3'd1,
    ST_FULL       = 3'd2,
    ST_BAD_MODE   = 3'd3,
    ST_WRONG_MODE = 3'd4,
    ST_OPEN       = 3'd5,
    ST_EOF        = 3'd6
  } status_e;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_WRITE  = 2'd2;
  localparam logic [1:0] MODE_APPEND = 2'd3;

endpackage

// ----- src/linked_block_file_store.sv -----
// response paths: open, close, bad request and a delete that frees nothing go straight
//   to the response; read follows links past exhausted blocks; write/append may step into
//   the next chain block or scan for a free one to link, and a start request first walks
//   the chain; delete frees the chain block by block; create scans the slots, then blocks
// requests: one in flight; the next is taken the cycle after the response loads
// reset: asynchronous, active low; a clearing pass marks every block free
module linked_block_file_store
  import lbfs_pkg::*;
#(
  parameter int FILE_SLOTS  = FileSlotsDef,
  parameter int BLOCK_COUNT = BlockCountDef,
  parameter int BLOCK_BYTES = BlockBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] req_type_i,
  input  logic [5:0] slot_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] data_byte_i,
  input  logic       start_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [5:0] slot_out_o,
  output logic [7:0] data_out_o
);

  localparam int SW  = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int BW  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int LW  = $clog2(BLOCK_COUNT + 2);
  localparam int FW  = $clog2(BLOCK_BYTES + 1);
  localparam int STW = $clog2(BLOCK_COUNT + 1);
  localparam int DAW = $clog2(BLOCK_COUNT * BLOCK_BYTES);
  localparam int BKW = LW + FW;
  localparam int DEPTH = BLOCK_COUNT * BLOCK_BYTES;

  // link codes above any block index
  localparam logic [LW-1:0] LINK_END  = LW'(BLOCK_COUNT);
  localparam logic [LW-1:0] LINK_FREE = LW'(BLOCK_COUNT + 1);
  localparam logic [LW-1:0] LINK_LIM  = LW'(BLOCK_COUNT);
  localparam logic [FW-1:0] FILL_MAX  = FW'(BLOCK_BYTES);
  localparam logic [BW-1:0] BLK_LAST  = BW'(BLOCK_COUNT - 1);
  localparam logic [SW-1:0] SLOT_LAST = SW'(FILE_SLOTS - 1);
  localparam logic [STW-1:0] STEP_LIM = STW'(BLOCK_COUNT);
  localparam logic [STW-1:0] STEP_PRE = STW'(BLOCK_COUNT - 1);

  typedef enum logic [16:0] {
    S_CLEAR   = 17'h00001,
    S_IDLE    = 17'h00002,
    S_EXEC    = 17'h00004,
    S_CS_SCAN = 17'h00008,
    S_FF_RD   = 17'h00010,
    S_FF_CHK  = 17'h00020,
    S_WK_RD   = 17'h00040,
    S_WK_WR   = 17'h00080,
    S_AP_RD   = 17'h00100,
    S_AP_CHK  = 17'h00200,
    S_PB_RD   = 17'h00400,
    S_PB_CHK  = 17'h00800,
    S_PB_NEW  = 17'h01000,
    S_GB_RD   = 17'h02000,
    S_GB_CHK  = 17'h04000,
    S_GB_DAT  = 17'h08000,
    S_RESP    = 17'h10000
  } state_e;

  function automatic logic [DAW-1:0] dat_addr(input logic [BW-1:0] b,
                                              input logic [FW-1:0] p);
    return DAW'(b) * DAW'(BLOCK_BYTES) + DAW'(p);
  endfunction

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  // request registers
  req_e          req_q;
  logic [1:0]    mode_q;
  logic [7:0]    byte_q;
  logic          start_q;
  logic [SW-1:0] idx_q;
  logic          slot_ok_q;

  // per-slot status flops, cleared by reset
  logic [FILE_SLOTS-1:0] slot_used_q, slot_used_d;
  logic [FILE_SLOTS-1:0] slot_open_q, slot_open_d;
  logic [1:0]            slot_mode_q [FILE_SLOTS];
  logic [1:0]            slot_mode_d [FILE_SLOTS];

  // shared cursor
  logic [BW-1:0] cur_blk_q, cur_blk_d;
  logic [FW-1:0] cur_pos_q, cur_pos_d;

  // sequencer working registers
  logic [SW-1:0]  cs_cnt_q, cs_cnt_d;
  logic [BW-1:0]  blk_cnt_q, blk_cnt_d;
  logic [STW-1:0] steps_q, steps_d;
  logic [BW-1:0]  wk_blk_q, wk_blk_d;
  logic [BW-1:0]  pb_blk_q, pb_blk_d;
  logic           pb_second_q, pb_second_d;
  logic [LW-1:0]  pb_link_q, pb_link_d;
  logic [FW-1:0]  pb_fill_q, pb_fill_d;

  // response being built and output register
  status_e    res_status_q, res_status_d;
  logic [5:0] res_slot_q, res_slot_d;
  logic [7:0] res_data_q, res_data_d;
  logic       out_valid_q, out_valid_d;
  logic       out_load;
  logic [2:0] out_status_q;
  logic [5:0] out_slot_q;
  logic [7:0] out_data_q;

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  logic [BW-1:0]  sfb_mem [FILE_SLOTS];
  logic           sfb_we;
  logic [SW-1:0]  sfb_wa, sfb_ra;
  logic [BW-1:0]  sfb_wd, sfb_rd_q;

  logic [BKW-1:0] blk_mem [BLOCK_COUNT];
  logic           blk_we;
  logic [BW-1:0]  blk_wa, blk_ra;
  logic [BKW-1:0] blk_wd, blk_rd_q;

  logic [7:0]     dat_mem [DEPTH];
  logic           dat_we;
  logic [DAW-1:0] dat_wa, dat_ra;
  logic [7:0]     dat_wd, dat_rd_q;

  always_ff @(posedge clk_i) begin
    if (sfb_we) begin
      sfb_mem[sfb_wa] <= sfb_wd;
    end
    sfb_rd_q <= sfb_mem[sfb_ra];
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_wa] <= blk_wd;
    end
    blk_rd_q <= blk_mem[blk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dat_we) begin
      dat_mem[dat_wa] <= dat_wd;
    end
    dat_rd_q <= dat_mem[dat_ra];
  end

  // fields of the block word read last cycle
  logic [LW-1:0] rd_link;
  logic [FW-1:0] rd_fill;
  assign rd_link = blk_rd_q[BKW-1:FW];
  assign rd_fill = blk_rd_q[FW-1:0];

  logic accept;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  logic slot_valid;
  assign slot_valid = slot_ok_q && slot_used_q[idx_q];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    slot_used_d  = slot_used_q;
    slot_open_d  = slot_open_q;
    slot_mode_d  = slot_mode_q;
    cur_blk_d    = cur_blk_q;
    cur_pos_d    = cur_pos_q;
    cs_cnt_d     = cs_cnt_q;
    blk_cnt_d    = blk_cnt_q;
    steps_d      = steps_q;
    wk_blk_d     = wk_blk_q;
    pb_blk_d     = pb_blk_q;
    pb_second_d  = pb_second_q;
    pb_link_d    = pb_link_q;
    pb_fill_d    = pb_fill_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_data_d   = res_data_q;

    sfb_we = 1'b0;
    sfb_wa = cs_cnt_q;
    sfb_wd = blk_cnt_q;
    sfb_ra = (state_q == S_IDLE) ? SW'(slot_i) : idx_q;

    blk_we = 1'b0;
    blk_wa = blk_cnt_q;
    blk_wd = {LINK_FREE, {FW{1'b0}}};
    blk_ra = blk_cnt_q;

    dat_we = 1'b0;
    dat_wa = dat_addr(pb_blk_q, rd_fill);
    dat_wd = byte_q;
    dat_ra = dat_addr(cur_blk_q, cur_pos_q);

    case (state_q)
      // sweep after reset: every block free, fill zero
      S_CLEAR: begin
        blk_we    = 1'b1;
        blk_cnt_d = blk_cnt_q + 1'b1;
        if (blk_cnt_q == BLK_LAST) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          res_slot_d   = slot_i;
          res_data_d   = 8'd0;
          res_status_d = ST_OK;
          state_d      = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_RESP;
        case (req_q)
          REQ_CREATE: begin
            cs_cnt_d = '0;
            state_d  = S_CS_SCAN;
          end
          REQ_OPEN: begin
            if (!slot_valid) begin
              res_status_d = ST_WRONG_MODE;
            end else begin
              slot_open_d[idx_q] = 1'b1;
              if (mode_q == MODE_NONE) begin
                res_status_d = ST_BAD_MODE;
              end else begin
                slot_mode_d[idx_q] = mode_q;
              end
            end
          end
          REQ_READ: begin
            if (!slot_valid || slot_mode_q[idx_q] != MODE_READ) begin
              res_status_d = ST_WRONG_MODE;
            end else begin
              if (start_q) begin
                cur_blk_d = sfb_rd_q;
                cur_pos_d = '0;
              end
              steps_d = '0;
              state_d = S_GB_RD;
            end
          end
          REQ_WRITE, REQ_APPEND: begin
            if (!slot_valid ||
                slot_mode_q[idx_q] != ((req_q == REQ_WRITE) ? MODE_WRITE : MODE_APPEND)) begin
              res_status_d = ST_WRONG_MODE;
            end else if (start_q) begin
              wk_blk_d = sfb_rd_q;
              steps_d  = '0;
              state_d  = (req_q == REQ_WRITE) ? S_WK_RD : S_AP_RD;
            end else begin
              pb_blk_d    = cur_blk_q;
              pb_second_d = 1'b0;
              state_d     = S_PB_RD;
            end
          end
          REQ_CLOSE: begin
            if (slot_ok_q) begin
              slot_open_d[idx_q] = 1'b0;
              slot_mode_d[idx_q] = MODE_NONE;
            end
          end
          REQ_DELETE: begin
            if (slot_valid) begin
              if (slot_open_q[idx_q]) begin
                res_status_d = ST_OPEN;
              end else begin
                wk_blk_d = sfb_rd_q;
                steps_d  = '0;
                state_d  = S_WK_RD;
              end
            end
          end
          default: begin
            res_status_d = ST_BAD_MODE;
          end
        endcase
      end

      // lowest unused slot
      S_CS_SCAN: begin
        if (!slot_used_q[cs_cnt_q]) begin
          blk_cnt_d = '0;
          state_d   = S_FF_RD;
        end else if (cs_cnt_q == SLOT_LAST) begin
          res_status_d = ST_NO_SLOT;
          state_d      = S_RESP;
        end else begin
          cs_cnt_d = cs_cnt_q + 1'b1;
        end
      end

      // lowest free block; each entry is read, then checked
      S_FF_RD: begin
        blk_ra  = blk_cnt_q;
        state_d = S_FF_CHK;
      end

      S_FF_CHK: begin
        if (rd_link == LINK_FREE) begin
          if (req_q == REQ_CREATE) begin
            slot_used_d[cs_cnt_q] = 1'b1;
            slot_open_d[cs_cnt_q] = 1'b0;
            slot_mode_d[cs_cnt_q] = MODE_NONE;
            sfb_we     = 1'b1;
            blk_we     = 1'b1;
            blk_wa     = blk_cnt_q;
            blk_wd     = {LINK_END, {FW{1'b0}}};
            res_slot_d = 6'(cs_cnt_q);
            state_d    = S_RESP;
          end else begin
            // hook the new block onto the end of the chain
            if (pb_link_q == LINK_END) begin
              blk_we = 1'b1;
              blk_wa = pb_blk_q;
              blk_wd = {LW'(blk_cnt_q), pb_fill_q};
            end
            state_d = S_PB_NEW;
          end
        end else if (blk_cnt_q == BLK_LAST) begin
          res_status_d = ST_FULL;
          state_d      = S_RESP;
        end else begin
          blk_cnt_d = blk_cnt_q + 1'b1;
          state_d   = S_FF_RD;
        end
      end

      // chain walk for truncate and delete
      S_WK_RD: begin
        blk_ra  = wk_blk_q;
        state_d = S_WK_WR;
      end

      S_WK_WR: begin
        blk_we = 1'b1;
        blk_wa = wk_blk_q;
        blk_wd = (req_q == REQ_DELETE) ? {LINK_FREE, {FW{1'b0}}} : {rd_link, {FW{1'b0}}};
        if (steps_q < STEP_PRE && rd_link < LINK_LIM) begin
          wk_blk_d = BW'(rd_link);
          steps_d  = steps_q + 1'b1;
          state_d  = S_WK_RD;
        end else if (req_q == REQ_DELETE) begin
          slot_used_d[idx_q] = 1'b0;
          slot_open_d[idx_q] = 1'b0;
          slot_mode_d[idx_q] = MODE_NONE;
          state_d            = S_RESP;
        end else begin
          cur_blk_d   = sfb_rd_q;
          cur_pos_d   = '0;
          pb_blk_d    = sfb_rd_q;
          pb_second_d = 1'b0;
          state_d     = S_PB_RD;
        end
      end

      // walk to the tail block for append
      S_AP_RD: begin
        blk_ra  = wk_blk_q;
        state_d = S_AP_CHK;
      end

      S_AP_CHK: begin
        if (steps_q < STEP_LIM && rd_link < LINK_LIM) begin
          wk_blk_d = BW'(rd_link);
          steps_d  = steps_q + 1'b1;
          state_d  = S_AP_RD;
        end else begin
          cur_blk_d   = wk_blk_q;
          cur_pos_d   = '0;
          pb_blk_d    = wk_blk_q;
          pb_second_d = 1'b0;
          state_d     = S_PB_RD;
        end
      end

      // store one byte
      S_PB_RD: begin
        blk_ra  = pb_blk_q;
        state_d = S_PB_CHK;
      end

      S_PB_CHK: begin
        if (rd_fill < FILL_MAX) begin
          dat_we    = 1'b1;
          dat_wa    = dat_addr(pb_blk_q, rd_fill);
          blk_we    = 1'b1;
          blk_wa    = pb_blk_q;
          blk_wd    = {rd_link, rd_fill + 1'b1};
          cur_blk_d = pb_blk_q;
          state_d   = S_RESP;
        end else if (pb_second_q) begin
          res_status_d = ST_FULL;
          state_d      = S_RESP;
        end else if (rd_link < LINK_LIM) begin
          pb_blk_d    = BW'(rd_link);
          pb_second_d = 1'b1;
          state_d     = S_PB_RD;
        end else begin
          pb_link_d = rd_link;
          pb_fill_d = rd_fill;
          blk_cnt_d = '0;
          state_d   = S_FF_RD;
        end
      end

      // first byte of a freshly linked block
      S_PB_NEW: begin
        blk_we    = 1'b1;
        blk_wa    = blk_cnt_q;
        blk_wd    = {LINK_END, FW'(1)};
        dat_we    = 1'b1;
        dat_wa    = dat_addr(blk_cnt_q, '0);
        cur_blk_d = blk_cnt_q;
        state_d   = S_RESP;
      end

      // fetch one byte, following links past exhausted blocks
      S_GB_RD: begin
        blk_ra  = cur_blk_q;
        state_d = S_GB_CHK;
      end

      S_GB_CHK: begin
        if (cur_pos_q < rd_fill && cur_pos_q < FILL_MAX) begin
          dat_ra    = dat_addr(cur_blk_q, cur_pos_q);
          cur_pos_d = cur_pos_q + 1'b1;
          state_d   = S_GB_DAT;
        end else if (rd_link >= LINK_LIM) begin
          res_status_d = ST_EOF;
          state_d      = S_RESP;
        end else begin
          cur_blk_d = BW'(rd_link);
          cur_pos_d = '0;
          if (steps_q == STEP_LIM) begin
            res_status_d = ST_EOF;
            state_d      = S_RESP;
          end else begin
            steps_d = steps_q + 1'b1;
            state_d = S_GB_RD;
          end
        end
      end

      S_GB_DAT: begin
        res_data_d = dat_rd_q;
        state_d    = S_RESP;
      end

      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register frees as soon as the consumer takes the response
  assign out_load = (state_q == S_RESP) && !(out_valid_q && out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      slot_used_q <= '0;
      slot_open_q <= '0;
      for (int i = 0; i < FILE_SLOTS; i++) begin
        slot_mode_q[i] <= MODE_NONE;
      end
      cur_blk_q   <= '0;
      cur_pos_q   <= '0;
      blk_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_used_q <= slot_used_d;
      slot_open_q <= slot_open_d;
      slot_mode_q <= slot_mode_d;
      cur_blk_q   <= cur_blk_d;
      cur_pos_q   <= cur_pos_d;
      blk_cnt_q   <= blk_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_e'(req_type_i);
      mode_q    <= mode_i;
      byte_q    <= data_byte_i;
      start_q   <= start_req_i;
      idx_q     <= SW'(slot_i);
      slot_ok_q <= (32'(slot_i) < FILE_SLOTS);
    end
    cs_cnt_q     <= cs_cnt_d;
    steps_q      <= steps_d;
    wk_blk_q     <= wk_blk_d;
    pb_blk_q     <= pb_blk_d;
    pb_second_q  <= pb_second_d;
    pb_link_q    <= pb_link_d;
    pb_fill_q    <= pb_fill_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_data_q   <= res_data_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_data_q   <= res_data_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_out_o  = out_slot_q;
  assign data_out_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_no_blk_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FF_RD || state_q == S_WK_RD || state_q == S_AP_RD ||
     state_q == S_PB_RD || state_q == S_GB_RD) |-> !blk_we)
    else $error("block memory written while a read of it is in flight");

  a_cursor_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_pos_q <= FILL_MAX)
    else $error("cursor position past end of block");

  a_accept_starts_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted request did not start execution");

  a_data_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> data_out_o == 8'd0)
    else $error("data returned with a failing status");

endmodule

// ----- test/lbfs_checker.sv -----
module lbfs_checker
  import lbfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [2:0] req_type_i,
  input  logic [5:0] slot_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] data_byte_i,
  input  logic       start_req_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [2:0] status_i,
  input  logic [5:0] slot_out_i,
  input  logic [7:0] data_out_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots   = FileSlotsDef;
  localparam int Blocks  = BlockCountDef;
  localparam int BlkSize = BlockBytesDef;
  localparam int LinkEnd  = Blocks;
  localparam int LinkFree = Blocks + 1;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot;
    logic [7:0] data;
  } response_t;

  // shadow copy of the store
  bit         slot_used  [Slots];
  int         first_blk  [Slots];
  bit         slot_open  [Slots];
  logic [1:0] slot_mode  [Slots];
  int         blk_link   [Blocks];
  int         blk_fill   [Blocks];
  logic [7:0] blk_data   [Blocks*BlkSize];
  int         cur_blk;
  int         cur_pos;

  response_t  expected_q[$];
  int         fails = 0;

  initial begin
    for (int i = 0; i < Slots; i++) begin
      slot_used[i] = 0; first_blk[i] = 0; slot_open[i] = 0; slot_mode[i] = MODE_NONE;
    end
    for (int b = 0; b < Blocks; b++) begin
      blk_link[b] = LinkFree;
      blk_fill[b] = 0;
    end
    cur_blk = 0;
    cur_pos = 0;
  end

  function automatic int lowest_free_block();
    for (int b = 0; b < Blocks; b++)
      if (blk_link[b] == LinkFree) return b;
    return Blocks;
  endfunction

  function automatic status_e store_byte(logic [7:0] v);
    int bn, nx;
    bn = cur_blk;
    if (bn >= Blocks) return ST_FULL;
    if (blk_fill[bn] >= BlkSize) begin
      nx = blk_link[bn];
      if (nx >= Blocks) begin
        nx = lowest_free_block();
        if (nx >= Blocks) return ST_FULL;
        if (blk_link[bn] == LinkEnd) blk_link[bn] = nx;
        blk_link[nx] = LinkEnd;
        blk_fill[nx] = 0;
      end
      bn = nx;
      if (blk_fill[bn] >= BlkSize) return ST_FULL;
    end
    blk_data[bn*BlkSize + blk_fill[bn]] = v;
    blk_fill[bn]++;
    cur_blk = bn;
    return ST_OK;
  endfunction

  function automatic status_e fetch_byte(output logic [7:0] v);
    v = '0;
    for (int steps = 0; steps <= Blocks; steps++) begin
      if (cur_blk >= Blocks) return ST_EOF;
      if (cur_pos < blk_fill[cur_blk] && cur_pos < BlkSize) begin
        v = blk_data[cur_blk*BlkSize + cur_pos];
        cur_pos++;
        return ST_OK;
      end
      if (blk_link[cur_blk] >= Blocks) return ST_EOF;
      cur_blk = blk_link[cur_blk];
      cur_pos = 0;
    end
    return ST_EOF;
  endfunction

  function automatic response_t apply_request(logic [2:0] req, logic [5:0] s, logic [1:0] md,
                                              logic [7:0] dbyte, logic start);
    response_t r;
    status_e   st;
    logic [7:0] rd;
    int bn, nx, fs, fb, steps;
    bit live;
    st = ST_OK;
    r.slot = s;
    r.data = '0;
    live = slot_used[s];
    case (req)
      REQ_CREATE: begin
        fs = 0;
        while (fs < Slots && slot_used[fs]) fs++;
        if (fs >= Slots) st = ST_NO_SLOT;
        else begin
          fb = lowest_free_block();
          if (fb >= Blocks) st = ST_FULL;
          else begin
            slot_used[fs] = 1;
            first_blk[fs] = fb;
            slot_open[fs] = 0;
            slot_mode[fs] = MODE_NONE;
            blk_link[fb] = LinkEnd;
            blk_fill[fb] = 0;
            r.slot = fs[5:0];
          end
        end
      end
      REQ_OPEN: begin
        if (!live) st = ST_WRONG_MODE;
        else begin
          slot_open[s] = 1;
          if (md == MODE_NONE) st = ST_BAD_MODE;
          else slot_mode[s] = md;
        end
      end
      REQ_READ: begin
        if (!live || slot_mode[s] != MODE_READ) st = ST_WRONG_MODE;
        else begin
          if (start) begin
            cur_blk = first_blk[s];
            cur_pos = 0;
          end
          st = fetch_byte(rd);
          if (st == ST_OK) r.data = rd;
        end
      end
      REQ_WRITE: begin
        if (!live || slot_mode[s] != MODE_WRITE) st = ST_WRONG_MODE;
        else begin
          if (start) begin
            // truncate: keep the chain, empty every block
            bn = first_blk[s];
            for (steps = 0; steps < Blocks && bn < Blocks; steps++) begin
              blk_fill[bn] = 0;
              bn = blk_link[bn];
            end
            cur_blk = first_blk[s];
            cur_pos = 0;
          end
          st = store_byte(dbyte);
        end
      end
      REQ_APPEND: begin
        if (!live || slot_mode[s] != MODE_APPEND) st = ST_WRONG_MODE;
        else begin
          if (start) begin
            bn = first_blk[s];
            for (steps = 0; steps < Blocks && bn < Blocks && blk_link[bn] < Blocks; steps++)
              bn = blk_link[bn];
            cur_blk = bn;
            cur_pos = 0;
          end
          st = store_byte(dbyte);
        end
      end
      REQ_CLOSE: begin
        slot_open[s] = 0;
        slot_mode[s] = MODE_NONE;
      end
      REQ_DELETE: begin
        if (live) begin
          if (slot_open[s]) st = ST_OPEN;
          else begin
            bn = first_blk[s];
            for (steps = 0; steps < Blocks && bn < Blocks; steps++) begin
              nx = blk_link[bn];
              blk_link[bn] = LinkFree;
              blk_fill[bn] = 0;
              bn = nx;
            end
            slot_used[s] = 0;
            slot_open[s] = 0;
            slot_mode[s] = MODE_NONE;
          end
        end
      end
      default: st = ST_BAD_MODE;
    endcase
    r.status = st;
    return r;
  endfunction

  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni) begin
      // compare before predicting: a response never leaves in its own request's cycle
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected response: status %0d slot %0d data %0h",
                     status_i, slot_out_i, data_out_i);
        end else begin
          want = expected_q.pop_front();
          if (status_i !== want.status || slot_out_i !== want.slot
              || data_out_i !== want.data) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected status %0d slot %0d data %0h, got %0d %0d %0h",
                       want.status, want.slot, want.data, status_i, slot_out_i, data_out_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q = {expected_q, apply_request(req_type_i, slot_i, mode_i, data_byte_i,
                                                start_req_i)};
    end
    pending_o    <= expected_q.size();
    fail_count_o <= fails;
  end

endmodule

// ----- test/tb_linked_block_file_store.sv -----
module tb_linked_block_file_store;
  import lbfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomRequests = 1700;
  localparam int CycleLimit     = 8000000;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid_i = 0;
  logic       in_stall_o;
  logic [2:0] req_type_i = '0;
  logic [5:0] slot_i = '0;
  logic [1:0] mode_i = '0;
  logic [7:0] data_byte_i = '0;
  logic       start_req_i = 0;
  logic       out_valid_o;
  logic       out_stall_i = 0;
  logic [2:0] status_o;
  logic [5:0] slot_out_o;
  logic [7:0] data_out_o;

  int fail_count;
  int pending;
  int cycles = 0;
  bit quiet = 0;           // no idling on either side while set
  int sent = 0;
  bit live [64];           // slots the stimulus believes are created

  always #1 clk_i = ~clk_i;

  linked_block_file_store dut (.*);

  lbfs_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .slot_i,
    .mode_i, .data_byte_i, .start_req_i, .out_valid_i(out_valid_o), .out_stall_i,
    .status_i(status_o), .slot_out_i(slot_out_o), .data_out_i(data_out_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls at random, about 9 percent of the time, except while quiet
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 9);
  end

  // hard stop if the block hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // drive one request and hold it until it is taken
  task automatic send(req_e req, logic [5:0] s, logic [1:0] md, logic [7:0] d, logic st);
    bit stalled;
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid_i <= 0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i  <= 1;
    req_type_i  <= req;
    slot_i      <= s;
    mode_i      <= md;
    data_byte_i <= d;
    start_req_i <= st;
    // stall is stable from negedge to the next rising edge
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    sent++;
  endtask

  task automatic send_raw(logic [2:0] req, logic [5:0] s, logic [1:0] md, logic [7:0] d,
                          logic st);
    send(req_e'(req), s, md, d, st);
  endtask

  function automatic int lowest_idle_slot();
    for (int i = 0; i < 64; i++)
      if (!live[i]) return i;
    return 64;
  endfunction

  function automatic int pick_live_slot();
    int tries;
    for (tries = 0; tries < 20; tries++) begin
      int k = $urandom_range(63);
      if (live[k]) return k;
    end
    for (int i = 0; i < 64; i++)
      if (live[i]) return i;
    return $urandom_range(63);
  endfunction

  // sessions: open, a run of byte requests, close
  task automatic byte_session(req_e req, logic [1:0] md);
    int s, n;
    s = pick_live_slot();
    n = ($urandom_range(9) == 0) ? $urandom_range(150, 60) : $urandom_range(20, 1);
    send(REQ_OPEN, 6'(s), md, 8'($urandom), 1'($urandom));
    for (int i = 0; i < n; i++)
      // the first request mostly starts clean, later ones mostly continue the shared cursor
      send(req, 6'(s), 2'($urandom), 8'($urandom),
           (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0));
    send(REQ_CLOSE, 6'(s), 2'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int pick, s;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;

    // directed: basic lifecycle and the corner statuses
    send(REQ_CREATE, 6'd63, MODE_NONE, 8'h00, 0);
    send(REQ_CREATE, 6'd0, MODE_NONE, 8'h00, 0);
    send(REQ_OPEN, 6'd0, MODE_NONE, 8'h00, 0);         // bad mode
    send(REQ_OPEN, 6'd0, MODE_WRITE, 8'h00, 0);
    send(REQ_WRITE, 6'd0, MODE_NONE, 8'h00, 1);
    send(REQ_WRITE, 6'd0, MODE_NONE, 8'hff, 0);
    send(REQ_APPEND, 6'd0, MODE_NONE, 8'h55, 1);        // wrong mode
    send(REQ_CLOSE, 6'd0, MODE_NONE, 8'h00, 0);
    send(REQ_OPEN, 6'd0, MODE_READ, 8'h00, 0);
    send(REQ_READ, 6'd0, MODE_NONE, 8'h00, 1);
    send(REQ_READ, 6'd0, MODE_NONE, 8'h00, 0);
    send(REQ_READ, 6'd0, MODE_NONE, 8'h00, 0);         // end of file
    send(REQ_READ, 6'd1, MODE_NONE, 8'h00, 1);         // slot closed
    send(REQ_DELETE, 6'd0, MODE_NONE, 8'h00, 0);       // refused, still open
    send(REQ_CLOSE, 6'd0, MODE_NONE, 8'h00, 0);
    send(REQ_OPEN, 6'd1, MODE_APPEND, 8'h00, 0);
    send(REQ_APPEND, 6'd1, MODE_NONE, 8'haa, 1);
    send(REQ_CLOSE, 6'd1, MODE_NONE, 8'h00, 0);
    send(REQ_DELETE, 6'd1, MODE_NONE, 8'h00, 0);
    send(REQ_DELETE, 6'd63, MODE_NONE, 8'h00, 0);      // unused slot
    send(REQ_OPEN, 6'd63, MODE_APPEND, 8'h00, 0);      // unused slot
    send_raw(3'd7, 6'd63, 2'd3, 8'hff, 1);             // unknown request
    // fill every slot, then one more create has no slot
    for (int i = 0; i < 64; i++) send(REQ_CREATE, 6'd0, MODE_NONE, 8'h00, 0);
    for (int i = 2; i < 64; i++) send(REQ_DELETE, i[5:0], MODE_NONE, 8'h00, 0);
    live[0] = 1;
    live[1] = 1;

    // random: mostly well-formed sessions with random content
    sent = 0;
    while (sent < RandomRequests) begin
      quiet = (sent > 500 && sent < 900);
      if (sent > 1200 && sent < 1250) wait_drained();   // sender holds off until drained
      pick = $urandom_range(99);
      if (pick < 12) begin
        s = lowest_idle_slot();
        send(REQ_CREATE, 6'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));
        if (s < 64) live[s] = 1;
      end else if (pick < 45) byte_session(REQ_WRITE, MODE_WRITE);
      else if (pick < 60) byte_session(REQ_APPEND, MODE_APPEND);
      else if (pick < 82) byte_session(REQ_READ, MODE_READ);
      else if (pick < 88) begin
        s = pick_live_slot();
        send(REQ_CLOSE, 6'(s), 2'($urandom), 8'($urandom), 1'($urandom));
        send(REQ_DELETE, 6'(s), 2'($urandom), 8'($urandom), 1'($urandom));
        live[s] = 0;
      end else
        send_raw(3'($urandom), 6'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));
    end
    quiet = 0;

    // drain, then a short tail for anything stray
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
